[hdl/rpq_pkg.sv]
// Shared types and constants for the ring priority queue.
`timescale 1ns / 1ps
`default_nettype none

package rpq_pkg;

   // Default sizing, handed to the top level parameters
   localparam int MAX_DEPTH_DEFAULT  = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;

   // Fixed field widths
   localparam int OP_WIDTH        = 2;
   localparam int PRIO_WIDTH      = 8;
   localparam int STATUS_WIDTH    = 2;
   localparam int CAP_WIDTH       = 5;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 8;

   // Register reset values
   localparam logic [CAP_WIDTH-1:0]  CAP_RESET      = 5'd16;
   localparam logic [PRIO_WIDTH-1:0] DEF_PRIO_RESET = 8'd16;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_PUSH_DEFAULT = 2'd0,
      OP_PUSH_PRIO    = 2'd1,
      OP_POP_FRONT    = 2'd2,
      OP_POP_HIGHEST  = 2'd3
   } op_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_ZERO_PRIO = 2'd3
   } status_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_CAPACITY     = 1'b0,
      CSR_DEFAULT_PRIO = 1'b1
   } csr_addr_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_CHECK,
      S_FRONT_WALK,
      S_SCAN,
      S_DECIDE,
      S_BACK_WALK,
      S_DONE
   } state_type;

   // Configuration registers as seen by the controller
   typedef struct packed {
      logic [CAP_WIDTH-1:0]  capacity;
      logic [PRIO_WIDTH-1:0] default_priority;
   } cfg_type;

   // Write strobes for the two stores
   typedef struct packed {
      logic prio_we;
      logic val_we;
   } mem_en_type;

endpackage

`default_nettype wire

[hdl/ring_priority_queue_top.sv]
// Ring priority queue top level: stream ports, configuration registers, stores.
// Push: checked and written in the check state, answered from the done state (a zero priority push skips the check).
// Pop-front: the front walk reads one slot a cycle up to the next entry; an empty queue skips it.
// Pop-highest: the scan reads one priority per
//   cycle, then a front or back pointer walk over the same memory port may follow.
// Reset clears the priority memory slot by slot; no request is taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module ring_priority_queue_top #(
   parameter int MAX_DEPTH  = rpq_pkg::MAX_DEPTH_DEFAULT,
   parameter int DATA_WIDTH = rpq_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   // request stream
   input  wire logic req_tvalid,
   output logic      req_tready,
   // operation, value, priority_req (from bit 0)
   input  wire logic [((rpq_pkg::OP_WIDTH + DATA_WIDTH + rpq_pkg::PRIO_WIDTH + 7) / 8) * 8 - 1:0]
                     req_tdata,
   // response stream
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   // out_value, status (from bit 0)
   output logic      [((DATA_WIDTH + rpq_pkg::STATUS_WIDTH + 7) / 8) * 8 - 1:0] rsp_tdata,
   // configuration writes
   input  wire logic                                  csr_we,
   input  wire logic [rpq_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire logic [rpq_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);

   localparam int IW    = $clog2(MAX_DEPTH);
   localparam int RSP_W = ((DATA_WIDTH + rpq_pkg::STATUS_WIDTH + 7) / 8) * 8;
   localparam int PW    = rpq_pkg::PRIO_WIDTH;

   rpq_pkg::cfg_type   cfg_ff, cfg_in;
   rpq_pkg::mem_en_type mem_en;

   logic [IW-1:0]       prio_waddr, prio_raddr, val_waddr, val_raddr;
   logic [PW-1:0]       prio_wdata, prio_rdata;
   logic [DATA_WIDTH-1:0] val_wdata, val_rdata;
   logic [DATA_WIDTH-1:0] rsp_value;
   logic [rpq_pkg::STATUS_WIDTH-1:0] rsp_status;

   // Configuration register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (rpq_pkg::csr_addr_type'(csr_index))
            rpq_pkg::CSR_CAPACITY:     cfg_in.capacity = csr_wdata[rpq_pkg::CAP_WIDTH-1:0];
            rpq_pkg::CSR_DEFAULT_PRIO: cfg_in.default_priority = csr_wdata[PW-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.capacity         <= rpq_pkg::CAP_RESET;
         cfg_ff.default_priority <= rpq_pkg::DEF_PRIO_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rpq_ctrl #(
      .MAX_DEPTH  (MAX_DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_op     (req_tdata[rpq_pkg::OP_WIDTH-1:0]),
      .req_value  (req_tdata[rpq_pkg::OP_WIDTH +: DATA_WIDTH]),
      .req_prio   (req_tdata[rpq_pkg::OP_WIDTH + DATA_WIDTH +: PW]),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_value  (rsp_value),
      .rsp_status (rsp_status),
      .mem_en     (mem_en),
      .prio_waddr (prio_waddr),
      .prio_wdata (prio_wdata),
      .prio_raddr (prio_raddr),
      .prio_rdata (prio_rdata),
      .val_waddr  (val_waddr),
      .val_wdata  (val_wdata),
      .val_raddr  (val_raddr),
      .val_rdata  (val_rdata)
   );

   // Priority store, zero marks an empty slot
   rpq_ram #(
      .WIDTH (PW),
      .DEPTH (MAX_DEPTH)
   ) u_prio_ram (
      .clock (clock),
      .we    (mem_en.prio_we),
      .waddr (prio_waddr),
      .wdata (prio_wdata),
      .raddr (prio_raddr),
      .rdata (prio_rdata)
   );

   // Value store
   rpq_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (MAX_DEPTH)
   ) u_val_ram (
      .clock (clock),
      .we    (mem_en.val_we),
      .waddr (val_waddr),
      .wdata (val_wdata),
      .raddr (val_raddr),
      .rdata (val_rdata)
   );

   assign rsp_tdata = RSP_W'({rsp_status, rsp_value});

endmodule

`default_nettype wire

[hdl/rpq_ram.sv]
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module rpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

[hdl/rpq_ctrl.sv]
// Queue controller: pointers, slot scans and walks over the stores, result register.
`timescale 1ns / 1ps
`default_nettype none

module rpq_ctrl #(
   parameter int MAX_DEPTH  = rpq_pkg::MAX_DEPTH_DEFAULT,
   parameter int DATA_WIDTH = rpq_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire rpq_pkg::cfg_type                      cfg,
   // request side
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [rpq_pkg::OP_WIDTH-1:0]          req_op,
   input  wire logic [DATA_WIDTH-1:0]                 req_value,
   input  wire logic [rpq_pkg::PRIO_WIDTH-1:0]        req_prio,
   // response side
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic      [DATA_WIDTH-1:0]                 rsp_value,
   output logic      [rpq_pkg::STATUS_WIDTH-1:0]      rsp_status,
   // store ports
   output rpq_pkg::mem_en_type                        mem_en,
   output logic      [$clog2(MAX_DEPTH)-1:0]          prio_waddr,
   output logic      [rpq_pkg::PRIO_WIDTH-1:0]        prio_wdata,
   output logic      [$clog2(MAX_DEPTH)-1:0]          prio_raddr,
   input  wire logic [rpq_pkg::PRIO_WIDTH-1:0]        prio_rdata,
   output logic      [$clog2(MAX_DEPTH)-1:0]          val_waddr,
   output logic      [DATA_WIDTH-1:0]                 val_wdata,
   output logic      [$clog2(MAX_DEPTH)-1:0]          val_raddr,
   input  wire logic [DATA_WIDTH-1:0]                 val_rdata
);

   localparam int IW = $clog2(MAX_DEPTH);
   localparam int SW = $clog2(MAX_DEPTH + 1);
   localparam int CW = (SW > rpq_pkg::CAP_WIDTH) ? SW : rpq_pkg::CAP_WIDTH;
   localparam int PW = rpq_pkg::PRIO_WIDTH;

   // Ring step forward with wrap at the slot count
   function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] i,
                                               input logic [SW-1:0] c);
      logic [SW-1:0] n;
      n = SW'(i) + SW'(1);
      return (n >= c) ? '0 : n[IW-1:0];
   endfunction

   // Ring step backward, slot 0 goes to the last slot in use
   function automatic logic [IW-1:0] prev_slot(input logic [IW-1:0] i,
                                               input logic [SW-1:0] c);
      return (i == '0) ? IW'(c - SW'(1)) : i - IW'(1);
   endfunction

   rpq_pkg::state_type  state_ff, state_in;
   logic [IW-1:0]       front_ff, front_in;
   logic [IW-1:0]       back_ff, back_in;
   logic [IW-1:0]       clr_ff, clr_in;
   rpq_pkg::op_type     op_ff, op_in;
   logic [DATA_WIDTH-1:0] value_ff, value_in;
   logic [PW-1:0]       prio_ff, prio_in;
   logic [IW-1:0]       cand_ff, cand_in;
   logic [SW-1:0]       cnt_ff, cnt_in;
   logic                pv_valid_ff, pv_valid_in;
   logic [IW-1:0]       pv_ptr_ff, pv_ptr_in;
   logic [IW-1:0]       best_ff, best_in;
   logic [PW-1:0]       best_prio_ff, best_prio_in;
   logic                val_cap_ff, val_cap_in;
   logic [DATA_WIDTH-1:0] res_value_ff, res_value_in;
   rpq_pkg::status_type res_status_ff, res_status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   rpq_pkg::status_type rsp_status_ff, rsp_status_in;

   logic [CW-1:0]       cap_ext;
   logic [SW-1:0]       slots;
   logic                accept;
   logic                req_is_push;
   logic [PW-1:0]       eff_prio;
   logic                ptr_eq;
   logic                front_busy;
   logic                queue_empty;
   logic                out_free;
   logic                pv_hit;
   logic                pv_better;
   logic                cand_at_back;
   logic                cnt_end;
   logic                best_at_front;
   logic                best_before_back;
   logic                clr_last;
   logic                start_front;

   // Slot count: zero counts as one, large values clamp to the store depth
   assign cap_ext = CW'(cfg.capacity);
   always_comb begin
      if (cap_ext == '0) begin
         slots = SW'(1);
      end else if (cap_ext > CW'(MAX_DEPTH)) begin
         slots = SW'(MAX_DEPTH);
      end else begin
         slots = SW'(cap_ext);
      end
   end

   // Shared decision terms
   assign req_ready   = (state_ff == rpq_pkg::S_IDLE);
   assign accept      = req_valid && req_ready;
   assign req_is_push = (rpq_pkg::op_type'(req_op) == rpq_pkg::OP_PUSH_DEFAULT) ||
                        (rpq_pkg::op_type'(req_op) == rpq_pkg::OP_PUSH_PRIO);
   assign eff_prio    = (rpq_pkg::op_type'(req_op) == rpq_pkg::OP_PUSH_DEFAULT) ?
                        cfg.default_priority : req_prio;
   assign ptr_eq      = (front_ff == back_ff);
   assign front_busy  = (prio_rdata != '0);
   assign queue_empty = ptr_eq && !front_busy;
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign pv_hit      = pv_valid_ff && (prio_rdata != '0);
   assign pv_better   = pv_valid_ff && (prio_rdata > best_prio_ff);
   assign cand_at_back = (cand_ff == back_ff);
   assign cnt_end     = (cnt_ff == slots);
   assign best_at_front = (best_ff == front_ff);
   assign best_before_back = (next_slot(best_ff, slots) == back_ff);
   assign clr_last    = (clr_ff == IW'(MAX_DEPTH - 1));
   assign start_front =
      ((state_ff == rpq_pkg::S_CHECK) && (op_ff == rpq_pkg::OP_POP_FRONT) && !queue_empty) ||
      ((state_ff == rpq_pkg::S_DECIDE) && best_at_front);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rpq_pkg::S_CLEAR: begin
            if (clr_last) state_in = rpq_pkg::S_IDLE;
         end
         rpq_pkg::S_IDLE: begin
            if (accept) begin
               if (req_is_push && (eff_prio == '0)) state_in = rpq_pkg::S_DONE;
               else                                 state_in = rpq_pkg::S_CHECK;
            end
         end
         rpq_pkg::S_CHECK: begin
            case (op_ff) inside
               rpq_pkg::OP_PUSH_DEFAULT, rpq_pkg::OP_PUSH_PRIO: state_in = rpq_pkg::S_DONE;
               default: begin
                  if (queue_empty)                          state_in = rpq_pkg::S_DONE;
                  else if (op_ff == rpq_pkg::OP_POP_FRONT)  state_in = rpq_pkg::S_FRONT_WALK;
                  else                                      state_in = rpq_pkg::S_SCAN;
               end
            endcase
         end
         rpq_pkg::S_FRONT_WALK: begin
            if (pv_hit || cand_at_back || cnt_end) state_in = rpq_pkg::S_DONE;
         end
         rpq_pkg::S_SCAN: begin
            if (cand_at_back || cnt_end) state_in = rpq_pkg::S_DECIDE;
         end
         rpq_pkg::S_DECIDE: begin
            if (best_at_front)         state_in = rpq_pkg::S_FRONT_WALK;
            else if (best_before_back) state_in = rpq_pkg::S_BACK_WALK;
            else                       state_in = rpq_pkg::S_DONE;
         end
         rpq_pkg::S_BACK_WALK: begin
            if (pv_hit || cnt_end) state_in = rpq_pkg::S_DONE;
         end
         rpq_pkg::S_DONE: begin
            if (out_free) state_in = rpq_pkg::S_IDLE;
         end
         default: state_in = rpq_pkg::S_IDLE;
      endcase
   end

   // Datapath, store accesses and result register
   always_comb begin
      front_in      = front_ff;
      back_in       = back_ff;
      clr_in        = clr_ff;
      op_in         = op_ff;
      value_in      = value_ff;
      prio_in       = prio_ff;
      cand_in       = cand_ff;
      cnt_in        = cnt_ff;
      pv_valid_in   = pv_valid_ff;
      pv_ptr_in     = pv_ptr_ff;
      best_in       = best_ff;
      best_prio_in  = best_prio_ff;
      val_cap_in    = 1'b0;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;

      mem_en        = '0;
      prio_waddr    = front_ff;
      prio_wdata    = '0;
      prio_raddr    = front_ff;
      val_waddr     = back_ff;
      val_wdata     = value_ff;
      val_raddr     = front_ff;

      unique case (state_ff)
         rpq_pkg::S_CLEAR: begin
            mem_en.prio_we = 1'b1;
            prio_waddr     = clr_ff;
            clr_in         = clr_ff + IW'(1);
         end
         rpq_pkg::S_IDLE: begin
            // front priority is read here for the full / empty test
            if (accept) begin
               op_in        = rpq_pkg::op_type'(req_op);
               value_in     = req_value;
               prio_in      = eff_prio;
               res_value_in = '0;
               res_status_in = (req_is_push && (eff_prio == '0)) ?
                               rpq_pkg::ST_ZERO_PRIO : rpq_pkg::ST_OK;
            end
         end
         rpq_pkg::S_CHECK: begin
            case (op_ff) inside
               rpq_pkg::OP_PUSH_DEFAULT, rpq_pkg::OP_PUSH_PRIO: begin
                  if (ptr_eq && front_busy) begin
                     res_status_in = rpq_pkg::ST_FULL;
                  end else begin
                     mem_en.val_we  = 1'b1;
                     mem_en.prio_we = 1'b1;
                     prio_waddr     = back_ff;
                     prio_wdata     = prio_ff;
                     back_in        = next_slot(back_ff, slots);
                  end
               end
               default: begin
                  if (queue_empty) begin
                     res_status_in = rpq_pkg::ST_EMPTY;
                  end else if (op_ff == rpq_pkg::OP_POP_HIGHEST) begin
                     best_in      = front_ff;
                     best_prio_in = prio_rdata;
                     cand_in      = next_slot(front_ff, slots);
                     cnt_in       = SW'(1);
                     pv_valid_in  = 1'b0;
                  end
               end
            endcase
         end
         rpq_pkg::S_FRONT_WALK: begin
            // stop at the first occupied slot, at the back, or after a full lap
            prio_raddr = cand_ff;
            if (pv_hit) begin
               front_in = pv_ptr_ff;
            end else if (cand_at_back || cnt_end) begin
               front_in = cand_ff;
            end else begin
               pv_valid_in = 1'b1;
               pv_ptr_in   = cand_ff;
               cand_in     = next_slot(cand_ff, slots);
               cnt_in      = cnt_ff + SW'(1);
            end
         end
         rpq_pkg::S_SCAN: begin
            // keep the first slot holding the strictly greatest priority
            prio_raddr = cand_ff;
            if (pv_better) begin
               best_in      = pv_ptr_ff;
               best_prio_in = prio_rdata;
            end
            if (!(cand_at_back || cnt_end)) begin
               pv_valid_in = 1'b1;
               pv_ptr_in   = cand_ff;
               cand_in     = next_slot(cand_ff, slots);
               cnt_in      = cnt_ff + SW'(1);
            end else begin
               pv_valid_in = 1'b0;
            end
         end
         rpq_pkg::S_DECIDE: begin
            // interior winner: leave a hole; if it was the last entry, walk back from the slot below
            if (!best_at_front) begin
               mem_en.prio_we = 1'b1;
               prio_waddr     = best_ff;
               val_raddr      = best_ff;
               val_cap_in     = 1'b1;
               cand_in        = prev_slot(best_ff, slots);
               cnt_in         = SW'(1);
               pv_valid_in    = 1'b0;
            end
         end
         rpq_pkg::S_BACK_WALK: begin
            prio_raddr = cand_ff;
            if (pv_hit) begin
               back_in = next_slot(pv_ptr_ff, slots);
            end else if (cnt_end) begin
               back_in = front_ff;
            end else begin
               pv_valid_in = 1'b1;
               pv_ptr_in   = cand_ff;
               cand_in     = prev_slot(cand_ff, slots);
               cnt_in      = cnt_ff + SW'(1);
            end
         end
         rpq_pkg::S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = val_cap_ff ? val_rdata : res_value_ff;
               rsp_status_in = res_status_ff;
            end
         end
         default: begin
         end
      endcase

      // Pop at the front: clear its priority, fetch its value, walk front on
      if (start_front) begin
         mem_en.prio_we = 1'b1;
         prio_waddr     = front_ff;
         val_raddr      = front_ff;
         val_cap_in     = 1'b1;
         cand_in        = next_slot(front_ff, slots);
         cnt_in         = SW'(1);
         pv_valid_in    = 1'b0;
      end

      // Value read data lands in the cycle after the read
      if (val_cap_ff) res_value_in = val_rdata;

      // Response taken with nothing new to load
      if (rsp_valid_ff && rsp_ready && !((state_ff == rpq_pkg::S_DONE) && out_free)) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rpq_pkg::S_CLEAR;
         front_ff     <= '0;
         back_ff      <= '0;
         clr_ff       <= '0;
         pv_valid_ff  <= 1'b0;
         val_cap_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         back_ff      <= back_in;
         clr_ff       <= clr_in;
         pv_valid_ff  <= pv_valid_in;
         val_cap_ff   <= val_cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      value_ff      <= value_in;
      prio_ff       <= prio_in;
      cand_ff       <= cand_in;
      cnt_ff        <= cnt_in;
      pv_ptr_ff     <= pv_ptr_in;
      best_ff       <= best_in;
      best_prio_ff  <= best_prio_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

endmodule

`default_nettype wire

[hdl/rpq_checker.sv]
// Port-level checks for the ring priority queue, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module rpq_checker #(
   parameter int DATA_WIDTH = rpq_pkg::DATA_WIDTH_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tvalid,
   input wire logic req_tready,
   input wire logic rsp_tvalid,
   input wire logic rsp_tready,
   input wire logic [((DATA_WIDTH + rpq_pkg::STATUS_WIDTH + 7) / 8) * 8 - 1:0] rsp_tdata
);

   // Reset leaves no response pending and holds off requests right after it
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && !req_tready))
      else $error("response or ready right after reset");

   // One request at a time: the cycle after an accepted request is busy
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while previous one in progress");

   // Failed operations return a zero value
   a_fail_zero_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid &&
       (rsp_tdata[DATA_WIDTH +: rpq_pkg::STATUS_WIDTH] !=
        rpq_pkg::STATUS_WIDTH'(rpq_pkg::ST_OK)))
      |-> (rsp_tdata[DATA_WIDTH-1:0] == '0))
      else $error("nonzero value on a failed operation");

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("response dropped or changed while stalled");

endmodule

bind ring_priority_queue_top rpq_checker #(
   .DATA_WIDTH (DATA_WIDTH)
) u_rpq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

[tb/sv/tb_ring_priority_queue_top.sv]
// Self-checking testbench for ring_priority_queue_top: directed and random requests.
`timescale 1ns / 1ps

module tb_ring_priority_queue_top;
   import rpq_pkg::*;

   localparam int DATA_BITS   = DATA_WIDTH_DEFAULT;
   localparam int RING_SLOTS  = MAX_DEPTH_DEFAULT;
   localparam int REQ_BITS    = ((OP_WIDTH + DATA_BITS + PRIO_WIDTH + 7) / 8) * 8;
   localparam int RSP_BITS    = ((DATA_BITS + STATUS_WIDTH + 7) / 8) * 8;
   localparam int MAX_GAP     = 12;
   localparam int SETTLE      = 2 * RING_SLOTS + 12;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASES      = 12;
   localparam int PHASE_ITEMS = 100;

   typedef struct packed {
      logic [DATA_BITS-1:0] value;
      status_type           status;
   } queue_outcome_type;

   // DUT ports
   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_BITS-1:0]       req_tdata  = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_BITS-1:0]       rsp_tdata;
   logic                      csr_we     = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata  = '0;

   // Predicted queue contents and registers
   logic [DATA_BITS-1:0]  q_value   [RING_SLOTS];
   logic [PRIO_WIDTH-1:0] q_prio    [RING_SLOTS];
   bit                    q_written [RING_SLOTS];
   logic [3:0]            q_front;
   logic [3:0]            q_back;
   logic [CAP_WIDTH-1:0]  cfg_capacity;
   logic [PRIO_WIDTH-1:0] cfg_default_prio;

   queue_outcome_type pending_outcomes[$];

   // Run control and bookkeeping
   bit          req_gaps_on   = 1'b1;
   bit          rsp_gaps_on   = 1'b1;
   int unsigned rsp_hold_cycles = 0;
   int unsigned cycle_count   = 0;
   int unsigned fail_count    = 0;
   int unsigned requests_sent = 0;
   int unsigned settings_used = 0;
   int unsigned status_seen [4];

   ring_priority_queue_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL ring_priority_queue_top");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor

   function automatic int unsigned ring_slots();
      int unsigned c;
      c = 32'(cfg_capacity);
      if (c < 1) c = 1;
      if (c > RING_SLOTS) c = RING_SLOTS;
      return c;
   endfunction

   // a pointer at or past the capacity wraps to slot 0 on its next step
   function automatic logic [3:0] ring_next(logic [3:0] i, int unsigned c);
      int unsigned n;
      n = i + 1;
      return (n >= c) ? 4'd0 : n[3:0];
   endfunction

   function automatic logic [3:0] ring_prev(logic [3:0] i, int unsigned c);
      int unsigned p;
      p = (i == 0) ? c - 1 : i - 1;
      return p[3:0];
   endfunction

   function automatic bit ring_empty();
      return q_front == q_back && q_prio[q_front] == 0;
   endfunction

   function automatic logic [DATA_BITS-1:0] take_front(int unsigned c);
      logic [DATA_BITS-1:0] v;
      v = q_value[q_front];
      q_prio[q_front] = '0;
      // skip holes up to the next entry or the back pointer
      for (int unsigned k = 0; k < c; k++) begin
         q_front = ring_next(q_front, c);
         if (q_front == q_back || q_prio[q_front] != 0) break;
      end
      return v;
   endfunction

   function automatic logic [DATA_BITS-1:0] take_highest(int unsigned c);
      logic [3:0]           best;
      logic [3:0]           s;
      logic [3:0]           b;
      bit                   found;
      logic [DATA_BITS-1:0] v;
      best = q_front;
      s    = q_front;
      // first strictly greatest priority, front to back
      for (int unsigned k = 0; k < c; k++) begin
         if (q_prio[s] > q_prio[best]) best = s;
         s = ring_next(s, c);
         if (s == q_back) break;
      end
      if (best == q_front) return take_front(c);
      v = q_value[best];
      q_prio[best] = '0;
      // last entry removed: pull the back pointer in over trailing holes
      if (ring_next(best, c) == q_back) begin
         b     = best;
         found = 1'b0;
         for (int unsigned k = 0; k < c; k++) begin
            if (q_prio[b] != 0) begin
               found = 1'b1;
               break;
            end
            b = ring_prev(b, c);
         end
         q_back = found ? ring_next(b, c) : q_front;
      end
      return v;
   endfunction

   function automatic queue_outcome_type apply_request(op_type op, logic [DATA_BITS-1:0] value,
                                                       logic [PRIO_WIDTH-1:0] prio_req);
      queue_outcome_type     res;
      int unsigned           c;
      logic [PRIO_WIDTH-1:0] prio;
      c          = ring_slots();
      res.value  = '0;
      res.status = ST_OK;
      if (op == OP_PUSH_DEFAULT || op == OP_PUSH_PRIO) begin
         prio = (op == OP_PUSH_DEFAULT) ? cfg_default_prio : prio_req;
         if (prio == 0) begin
            res.status = ST_ZERO_PRIO;
         end else if (q_front == q_back && q_prio[q_front] != 0) begin
            res.status = ST_FULL;
         end else begin
            q_value[q_back]   = value;
            q_prio[q_back]    = prio;
            q_written[q_back] = 1'b1;
            q_back            = ring_next(q_back, c);
         end
      end else if (ring_empty()) begin
         res.status = ST_EMPTY;
      end else if (op == OP_POP_FRONT) begin
         res.value = take_front(c);
      end else begin
         res.value = take_highest(c);
      end
      return res;
   endfunction

   // ---------------------------------------------------------------- drivers

   // one request: random gap, offer, wait for acceptance, then predict
   task automatic send_request(op_type op, logic [DATA_BITS-1:0] value,
                               logic [PRIO_WIDTH-1:0] prio);
      int unsigned gap;
      gap = req_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_BITS'({prio, value, op});
      do @(posedge clock); while (req_tready !== 1'b1);
      pending_outcomes.insert(pending_outcomes.size(), apply_request(op, value, prio));
      requests_sent++;
   endtask

   // stop offering and wait until every response is back and the block is quiet
   task automatic await_idle();
      req_tvalid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // both registers, written back to back while idle
   task automatic configure(logic [CAP_WIDTH-1:0] capacity, logic [PRIO_WIDTH-1:0] def_prio);
      await_idle();
      csr_we    <= 1'b1;
      csr_index <= CSR_CAPACITY;
      csr_wdata <= CSR_DATA_WIDTH'(capacity);
      @(posedge clock);
      cfg_capacity = capacity;
      csr_index <= CSR_DEFAULT_PRIO;
      csr_wdata <= def_prio;
      @(posedge clock);
      cfg_default_prio = def_prio;
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // response sink: random stall per response, plus an optional long hold-off
   initial begin : response_sink
      int unsigned gap;
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold_cycles != 0) begin
            rsp_tready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end
         gap = rsp_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid === 1'b1 && rsp_tready));
      end
   end

   // response checker
   always @(posedge clock) begin
      queue_outcome_type expected;
      logic [DATA_BITS-1:0]    got_value;
      logic [STATUS_WIDTH-1:0] got_status;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         got_value  = rsp_tdata[DATA_BITS-1:0];
         got_status = rsp_tdata[DATA_BITS +: STATUS_WIDTH];
         if (!$isunknown(got_status)) status_seen[got_status]++;
         if (pending_outcomes.size() == 0) begin
            $error("response with none expected: out_value %h status %0d", got_value, got_status);
            fail_count++;
         end else begin
            expected = pending_outcomes[0];
            pending_outcomes.delete(0);
            if (got_status !== expected.status) begin
               $error("status: expected %0d, actual %0d", expected.status, got_status);
               fail_count++;
            end
            if (got_value !== expected.value) begin
               $error("out_value: expected %h, actual %h", expected.value, got_value);
               fail_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- tests

   // pops on an empty queue and a zero priority push
   task automatic test_empty_and_invalid();
      configure(CAP_RESET, DEF_PRIO_RESET);
      send_request(OP_POP_FRONT, 32'hFFFF_FFFF, 8'hFF);
      send_request(OP_POP_HIGHEST, 32'h0, 8'h0);
      send_request(OP_PUSH_PRIO, 32'hDEAD_BEEF, 8'h00);
   endtask

   // pop-highest: tie goes to the first, middle hole, back pull-in, front case
   task automatic test_pop_highest_cases();
      send_request(OP_PUSH_DEFAULT, 32'h0000_0000, 8'h00);
      send_request(OP_PUSH_PRIO, 32'hFFFF_FFFF, 8'hFF);
      send_request(OP_PUSH_PRIO, 32'hAAAA_AAAA, 8'h01);
      send_request(OP_PUSH_PRIO, 32'h5555_5555, 8'hFF);
      send_request(OP_PUSH_PRIO, 32'h1234_5678, 8'h80);
      send_request(OP_POP_HIGHEST, 32'h0, 8'h0);
      send_request(OP_POP_HIGHEST, 32'h0, 8'h0);
      send_request(OP_POP_HIGHEST, 32'h0, 8'h0);
      send_request(OP_POP_FRONT, 32'h0, 8'h0);
      send_request(OP_POP_HIGHEST, 32'h0, 8'h0);
   endtask

   // small ring: back pointer wraps below slot 0, full ring, default priority zero
   task automatic test_wrap_and_full();
      configure(5'd4, DEF_PRIO_RESET);
      send_request(OP_PUSH_PRIO, 32'h0000_00A5, 8'd5);
      send_request(OP_PUSH_PRIO, 32'h0000_00B9, 8'd9);
      send_request(OP_POP_HIGHEST, 32'h0, 8'h0);
      send_request(OP_PUSH_DEFAULT, 32'h0000_00C0, 8'h0);
      send_request(OP_PUSH_PRIO, 32'h0000_00D0, 8'hFF);
      send_request(OP_PUSH_PRIO, 32'h0000_00E0, 8'h01);
      send_request(OP_PUSH_PRIO, 32'h0000_00F0, 8'h07);
      configure(5'd4, 8'd0);
      send_request(OP_PUSH_DEFAULT, 32'h0000_0F00, 8'h0);
      send_request(OP_POP_HIGHEST, 32'h0, 8'h0);
      send_request(OP_POP_FRONT, 32'h0, 8'h0);
   endtask

   // one random request; pops that would hit a never-written slot become pushes
   task automatic random_request(int unsigned push_pct);
      op_type                op;
      logic [DATA_BITS-1:0]  value;
      logic [PRIO_WIDTH-1:0] prio;
      int unsigned           r;
      r = $urandom_range(0, 99);
      if (r < push_pct) op = $urandom_range(0, 1) ? OP_PUSH_PRIO : OP_PUSH_DEFAULT;
      else op = $urandom_range(0, 1) ? OP_POP_HIGHEST : OP_POP_FRONT;
      value = $urandom();
      r = $urandom_range(0, 31);
      if (r == 0) value = '0;
      else if (r == 1) value = '1;
      r = $urandom_range(0, 99);
      if (r < 4) prio = 8'd0;
      else if (r < 10) prio = 8'hFF;
      else if (r < 14) prio = 8'd1;
      else if (r < 70) prio = 8'($urandom_range(1, 6));
      else prio = 8'($urandom_range(0, 255));
      if ((op == OP_POP_FRONT || op == OP_POP_HIGHEST) && !ring_empty() &&
          q_prio[q_front] == 0 && !q_written[q_front])
         op = OP_PUSH_PRIO;
      send_request(op, value, prio);
   endtask

   // sink holds off for a long stretch while requests keep coming
   task automatic test_backpressure();
      configure(5'd16, 8'd9);
      req_gaps_on     = 1'b0;
      rsp_gaps_on     = 1'b0;
      rsp_hold_cycles = 300;
      repeat (30) random_request(60);
      await_idle();
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
   endtask

   // random phases over several register settings; contents carry across them
   task automatic test_random_traffic(int unsigned first, int unsigned last);
      logic [CAP_WIDTH-1:0]  caps  [PHASES] = '{5'd16, 5'd1, 5'd0, 5'd7, 5'd31, 5'd2,
                                              5'd16, 5'd5, 5'd3, 5'd12, 5'd20, 5'd9};
      logic [PRIO_WIDTH-1:0] prios [PHASES] = '{8'd255, 8'd1, 8'd0, 8'd16, 8'd200, 8'd3,
                                              8'd1, 8'd255, 8'd7, 8'd0, 8'd64, 8'd128};
      int unsigned push_pct;
      for (int unsigned p = first; p <= last; p++) begin
         configure(caps[p], prios[p]);
         req_gaps_on = (p % 4 == 0) || (p % 4 == 2);
         rsp_gaps_on = (p % 4 == 0) || (p % 4 == 3);
         push_pct    = (p % 3 == 0) ? 70 : (p % 3 == 1) ? 35 : 50;
         for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
            random_request(push_pct);
            // now and then the sender waits for everything to drain
            if ($urandom_range(0, 49) == 0) await_idle();
         end
      end
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin : main
      for (int i = 0; i < RING_SLOTS; i++) begin
         q_value[i]   = '0;
         q_prio[i]    = '0;
         q_written[i] = 1'b0;
      end
      q_front          = '0;
      q_back           = '0;
      cfg_capacity     = CAP_RESET;
      cfg_default_prio = DEF_PRIO_RESET;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_empty_and_invalid();
      test_pop_highest_cases();
      test_wrap_and_full();
      test_random_traffic(0, PHASES / 2 - 1);
      test_backpressure();
      test_random_traffic(PHASES / 2, PHASES - 1);
      await_idle();

      $display("Sent %0d requests across %0d register settings, with stalls on both sides.",
               requests_sent, settings_used);
      $display("Responses: %0d ok, %0d full, %0d empty, %0d zero priority.",
               status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
               status_seen[ST_ZERO_PRIO]);
      if (fail_count == 0) begin
         $display("PASS ring_priority_queue_top");
      end else begin
         $display("FAIL ring_priority_queue_top");
      end
      $finish;
   end

endmodule
